FILE: hw/rtl/dcr_pkg.sv
// Shared types, constants and helpers for the disc collision resolver.
// Used by every module under hw/rtl; no dependencies of its own.
`timescale 1ns / 1ps
package dcr_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int REST_W          = 9;
    localparam int RESTITUTION_RST = 256;
    localparam int COORD_W         = 32;
    localparam int POS_W           = 31;
    localparam int ROOT_W          = 32;
    localparam int RAD_W           = 2 * ROOT_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_vx;
        logic signed [COORD_W-1:0] first_vy;
        logic        [POS_W-1:0]   first_radius;
        logic        [POS_W-1:0]   first_mass;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_vx;
        logic signed [COORD_W-1:0] second_vy;
        logic        [POS_W-1:0]   second_radius;
        logic        [POS_W-1:0]   second_mass;
    } disc_pair_t;

    typedef struct packed {
        logic                      collided;
        logic signed [COORD_W-1:0] new_first_x;
        logic signed [COORD_W-1:0] new_first_y;
        logic signed [COORD_W-1:0] new_first_vx;
        logic signed [COORD_W-1:0] new_first_vy;
        logic signed [COORD_W-1:0] new_second_x;
        logic signed [COORD_W-1:0] new_second_y;
        logic signed [COORD_W-1:0] new_second_vx;
        logic signed [COORD_W-1:0] new_second_vy;
    } disc_result_t;

    // Rides along the square-root pipeline.
    typedef struct packed {
        disc_pair_t          pair;
        logic [COORD_W-1:0]  adx;
        logic [COORD_W-1:0]  ady;
        logic [COORD_W-1:0]  rs;
        logic                neg_dx;
        logic                neg_dy;
        logic                coincident;
        logic                overlap;
    } sq_side_t;

    // Rides along the normal divider pipeline.
    typedef struct packed {
        disc_pair_t          pair;
        logic [COORD_W-1:0]  rs;
        logic [ROOT_W-1:0]   root_dist;
        logic                neg_dx;
        logic                coincident;
        logic                overlap;
    } dv_side_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/dcr_front.sv
// Front end: center deltas, radius sum, squared distances and overlap test.
// Three register stages; depends on dcr_pkg.
`timescale 1ns / 1ps
module dcr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 src_valid,
    input  dcr_pkg::disc_pair_t  pair,
    output logic                 dst_valid,
    output logic [dcr_pkg::RAD_W-1:0] radicand,
    output dcr_pkg::sq_side_t    dst_side
);
    localparam int CW = dcr_pkg::COORD_W;

    // stage A
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [CW:0]          adx_full;
    logic [CW:0]          ady_full;
    logic [CW-1:0]        rs;
    logic                 a_vld_reg;
    dcr_pkg::disc_pair_t  a_pair_reg;
    logic [CW-1:0]        a_adx_reg;
    logic [CW-1:0]        a_ady_reg;
    logic [CW-1:0]        a_rs_reg;
    logic                 a_lt_reg;
    logic                 a_negx_reg;
    logic                 a_negy_reg;
    logic                 a_zero_reg;
    // stage B
    logic                 b_vld_reg;
    dcr_pkg::sq_side_t    b_side_reg;
    logic [2*CW-1:0]      b_a_reg;
    logic [2*CW-1:0]      b_b_reg;
    logic [2*CW-1:0]      b_c_reg;
    logic                 b_lt_reg;
    // stage C
    logic [2*CW:0]        sum;
    logic                 c_vld_reg;
    logic [2*CW-1:0]      c_rad_reg;
    dcr_pkg::sq_side_t    c_side_reg;
    dcr_pkg::sq_side_t    c_side_next;

    always_comb
    begin
        dx = $signed({pair.second_x[CW-1], pair.second_x})
           - $signed({pair.first_x[CW-1], pair.first_x});
        dy = $signed({pair.second_y[CW-1], pair.second_y})
           - $signed({pair.first_y[CW-1], pair.first_y});
        adx_full = dx[CW] ? unsigned'(-dx) : unsigned'(dx);
        ady_full = dy[CW] ? unsigned'(-dy) : unsigned'(dy);
        rs = {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= src_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_comb
    begin
        sum = {1'b0, b_a_reg} + {1'b0, b_b_reg};
        c_side_next = b_side_reg;
        c_side_next.overlap = b_lt_reg && (sum < {1'b0, b_c_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pair_reg <= pair;
            a_adx_reg  <= adx_full[CW-1:0];
            a_ady_reg  <= ady_full[CW-1:0];
            a_rs_reg   <= rs;
            a_lt_reg   <= (adx_full < {1'b0, rs}) && (ady_full < {1'b0, rs});
            a_negx_reg <= dx[CW];
            a_negy_reg <= dy[CW];
            a_zero_reg <= (dx == '0) && (dy == '0);

            b_a_reg    <= a_adx_reg * a_adx_reg;
            b_b_reg    <= a_ady_reg * a_ady_reg;
            b_c_reg    <= a_rs_reg * a_rs_reg;
            b_lt_reg   <= a_lt_reg;
            b_side_reg <= '{pair: a_pair_reg, adx: a_adx_reg, ady: a_ady_reg,
                            rs: a_rs_reg, neg_dx: a_negx_reg, neg_dy: a_negy_reg,
                            coincident: a_zero_reg, overlap: 1'b0};

            c_rad_reg  <= sum[2*CW-1:0];
            c_side_reg <= c_side_next;
        end
    end

    assign dst_valid = c_vld_reg;
    assign radicand  = c_rad_reg;
    assign dst_side  = c_side_reg;
endmodule

FILE: hw/rtl/dcr_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on dcr_pkg for the radicand and root widths.
`timescale 1ns / 1ps
module dcr_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       src_valid,
    input  logic [dcr_pkg::RAD_W-1:0]  radicand,
    input  logic [SIDE_W-1:0]          src_side,
    output logic                       dst_valid,
    output logic [dcr_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]          dst_side
);
    localparam int STEPS = dcr_pkg::ROOT_W;
    localparam int NW    = dcr_pkg::RAD_W;
    localparam int TW    = NW + 2;

    logic              vld_reg  [STEPS];
    logic [NW-1:0]     rem_reg  [STEPS];
    logic [STEPS-1:0]  root_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int B = STEPS - 1 - k;
        logic              vld_in;
        logic [NW-1:0]     rem_in;
        logic [STEPS-1:0]  root_in;
        logic [SIDE_W-1:0] side_in;
        logic [TW-1:0]     trial;
        logic              take_bit;
        logic [NW-1:0]     rem_next;
        logic [STEPS-1:0]  root_next;

        if (k == 0)
        begin : g_head
            assign vld_in  = src_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign side_in = src_side;
        end
        else
        begin : g_body
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B)
        always_comb
        begin
            trial     = ({{(TW-STEPS){1'b0}}, root_in} << (B + 1))
                      + ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
            take_bit  = {2'b00, rem_in} >= trial;
            rem_next  = take_bit ? rem_in - trial[NW-1:0] : rem_in;
            root_next = take_bit ? (root_in | ({{(STEPS-1){1'b0}}, 1'b1} << B)) : root_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign dst_valid = vld_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign dst_side  = side_reg[STEPS-1];
endmodule

FILE: hw/rtl/dcr_div.sv
// Pipelined restoring divider: quot = floor(numer * 2^FRAC / denom), one bit a stage.
// Needs numer <= denom; depends on dcr_pkg for the operand width.
`timescale 1ns / 1ps
module dcr_div #(
    parameter int FRAC   = dcr_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        src_valid,
    input  logic [dcr_pkg::COORD_W-1:0] numer,
    input  logic [dcr_pkg::COORD_W-1:0] denom,
    input  logic [SIDE_W-1:0]           src_side,
    output logic                        dst_valid,
    output logic [FRAC:0]               quot,
    output logic                        rem_nz,
    output logic [SIDE_W-1:0]           dst_side
);
    localparam int DW    = dcr_pkg::COORD_W;
    localparam int STEPS = FRAC + 1;
    localparam int RW    = DW + FRAC + 1;

    logic              vld_reg  [STEPS];
    logic [RW-1:0]     rem_reg  [STEPS];
    logic [FRAC:0]     quot_reg [STEPS];
    logic [DW-1:0]     den_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int J = FRAC - k;
        logic              vld_in;
        logic [RW-1:0]     rem_in;
        logic [FRAC:0]     quot_in;
        logic [DW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW-1:0]     trial;
        logic              take_bit;

        if (k == 0)
        begin : g_head
            assign vld_in  = src_valid;
            assign rem_in  = {{(RW-DW){1'b0}}, numer} << FRAC;
            assign quot_in = '0;
            assign den_in  = denom;
            assign side_in = src_side;
        end
        else
        begin : g_body
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial    = {{(RW-DW){1'b0}}, den_in} << J;
            take_bit = rem_in >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take_bit ? rem_in - trial : rem_in;
                quot_reg[k] <= take_bit ? (quot_in | ({{FRAC{1'b0}}, 1'b1} << J)) : quot_in;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign dst_valid = vld_reg[STEPS-1];
    assign quot      = quot_reg[STEPS-1];
    assign rem_nz    = rem_reg[STEPS-1] != '0;
    assign dst_side  = side_reg[STEPS-1];
endmodule

FILE: hw/rtl/dcr_resolve.sv
// Back end: signed normal, approach test, impulse and separation, saturation.
// Six register stages; depends on dcr_pkg.
`timescale 1ns / 1ps
module dcr_resolve #(
    parameter int FRAC = dcr_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         src_valid,
    input  dcr_pkg::dv_side_t            side,
    input  logic                         neg_dy,
    input  logic [FRAC:0]                qx,
    input  logic [FRAC:0]                qy,
    input  logic [FRAC:0]                qm,
    input  logic                         m_rem_nz,
    input  logic                         msum_zero,
    input  logic [dcr_pkg::REST_W-1:0]   restitution,
    output logic                         dst_valid,
    output dcr_pkg::disc_result_t        result
);
    localparam int CW   = dcr_pkg::COORD_W;
    localparam int NW   = FRAC + 2;          // signed normal component
    localparam int WW   = FRAC + 1;          // mass weight
    localparam int DPW  = CW + 1 + NW;       // dv * n
    localparam int RVW  = DPW + 1;
    localparam int RQW  = RVW - FRAC;
    localparam int GW   = dcr_pkg::REST_W + 3;
    localparam int SPW  = RQW + GW;
    localparam int SW   = SPW - 8;
    localparam int KPW  = SW + WW + 1;
    localparam int KW   = KPW - FRAC;
    localparam int TPW  = KW + NW;
    localparam int TW   = TPW - FRAC;
    localparam int OVW  = CW - 1;
    localparam int PPW  = CW + NW;
    localparam int PW   = PPW - FRAC;

    localparam logic [FRAC:0] ONE  = {1'b1, {FRAC{1'b0}}};
    localparam logic [FRAC:0] HALF = {2'b01, {(FRAC-1){1'b0}}};

    // stage 1
    logic [FRAC:0]          magx;
    logic [FRAC:0]          magy;
    logic signed [NW-1:0]   nx;
    logic signed [NW-1:0]   ny;
    logic [WW:0]            w2_full;
    logic signed [CW:0]     dvx;
    logic signed [CW:0]     dvy;
    logic signed [DPW-1:0]  dpx;
    logic signed [DPW-1:0]  dpy;
    logic                   vld1_reg;
    dcr_pkg::dv_side_t      side1_reg;
    logic signed [NW-1:0]   nx1_reg;
    logic signed [NW-1:0]   ny1_reg;
    logic [WW-1:0]          w1_1_reg;
    logic [WW-1:0]          w2_1_reg;
    logic signed [DPW-1:0]  dpx1_reg;
    logic signed [DPW-1:0]  dpy1_reg;
    // stage 2
    logic signed [RVW-1:0]  rv;
    logic signed [RVW-1:0]  rv_sh;
    logic [CW-1:0]          gap;
    logic                   vld2_reg;
    dcr_pkg::disc_pair_t    pair2_reg;
    logic signed [NW-1:0]   nx2_reg;
    logic signed [NW-1:0]   ny2_reg;
    logic [WW-1:0]          w1_2_reg;
    logic [WW-1:0]          w2_2_reg;
    logic signed [RQW-1:0]  rvq2_reg;
    logic [OVW-1:0]         ov2_reg;
    logic                   hit2_reg;
    // stage 3
    logic [GW-2:0]          gain;
    logic signed [SPW-1:0]  sp;
    logic signed [SPW-1:0]  sp_sh;
    logic signed [PPW-1:0]  ppx;
    logic signed [PPW-1:0]  ppy;
    logic                   vld3_reg;
    dcr_pkg::disc_pair_t    pair3_reg;
    logic signed [NW-1:0]   nx3_reg;
    logic signed [NW-1:0]   ny3_reg;
    logic [WW-1:0]          w1_3_reg;
    logic [WW-1:0]          w2_3_reg;
    logic signed [SW-1:0]   s3_reg;
    logic signed [PPW-1:0]  ppx3_reg;
    logic signed [PPW-1:0]  ppy3_reg;
    logic                   hit3_reg;
    // stage 4
    logic signed [KPW-1:0]  kp1;
    logic signed [KPW-1:0]  kp2;
    logic signed [KPW-1:0]  kp1_sh;
    logic signed [KPW-1:0]  kp2_sh;
    logic signed [PPW-1:0]  ppx_sh;
    logic signed [PPW-1:0]  ppy_sh;
    logic                   vld4_reg;
    dcr_pkg::disc_pair_t    pair4_reg;
    logic signed [NW-1:0]   nx4_reg;
    logic signed [NW-1:0]   ny4_reg;
    logic signed [KW-1:0]   k1_4_reg;
    logic signed [KW-1:0]   k2_4_reg;
    logic signed [PW-1:0]   px4_reg;
    logic signed [PW-1:0]   py4_reg;
    logic                   hit4_reg;
    // stage 5
    logic signed [TPW-1:0]  tp1x;
    logic signed [TPW-1:0]  tp1y;
    logic signed [TPW-1:0]  tp2x;
    logic signed [TPW-1:0]  tp2y;
    logic signed [TPW-1:0]  tp1x_sh;
    logic signed [TPW-1:0]  tp1y_sh;
    logic signed [TPW-1:0]  tp2x_sh;
    logic signed [TPW-1:0]  tp2y_sh;
    logic                   vld5_reg;
    dcr_pkg::disc_pair_t    pair5_reg;
    logic signed [TW-1:0]   t1x5_reg;
    logic signed [TW-1:0]   t1y5_reg;
    logic signed [TW-1:0]   t2x5_reg;
    logic signed [TW-1:0]   t2y5_reg;
    logic signed [PW-1:0]   px5_reg;
    logic signed [PW-1:0]   py5_reg;
    logic                   hit5_reg;
    // stage 6
    dcr_pkg::disc_result_t  res_next;
    logic                   vld6_reg;
    dcr_pkg::disc_result_t  res6_reg;

    // Signed normal, mass weights and the two halves of the approach dot product.
    always_comb
    begin
        magx    = side.coincident ? ONE : qx;
        magy    = side.coincident ? '0 : qy;
        nx      = side.neg_dx ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        ny      = neg_dy ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
        // floor(m2*2^F/S) = 2^F - w1, less one when the first quotient left a remainder
        w2_full = {1'b0, ONE} - {1'b0, qm} - {{WW{1'b0}}, m_rem_nz};
        dvx     = $signed({side.pair.second_vx[CW-1], side.pair.second_vx})
                - $signed({side.pair.first_vx[CW-1], side.pair.first_vx});
        dvy     = $signed({side.pair.second_vy[CW-1], side.pair.second_vy})
                - $signed({side.pair.first_vy[CW-1], side.pair.first_vy});
        dpx     = dvx * nx;
        dpy     = dvy * ny;
    end

    always_comb
    begin
        rv    = RVW'(dpx1_reg) + RVW'(dpy1_reg);
        rv_sh = rv >>> FRAC;
        gap   = side1_reg.rs - side1_reg.root_dist;
    end

    always_comb
    begin
        gain  = {2'b00, restitution} + (GW-1)'(256);
        sp    = rvq2_reg * $signed({1'b0, gain});
        sp_sh = sp >>> 8;
        ppx   = $signed({1'b0, ov2_reg}) * nx2_reg;
        ppy   = $signed({1'b0, ov2_reg}) * ny2_reg;
    end

    always_comb
    begin
        kp1    = s3_reg * $signed({1'b0, w2_3_reg});
        kp2    = s3_reg * $signed({1'b0, w1_3_reg});
        kp1_sh = kp1 >>> FRAC;
        kp2_sh = kp2 >>> FRAC;
        ppx_sh = ppx3_reg >>> FRAC;
        ppy_sh = ppy3_reg >>> FRAC;
    end

    always_comb
    begin
        tp1x    = k1_4_reg * nx4_reg;
        tp1y    = k1_4_reg * ny4_reg;
        tp2x    = k2_4_reg * nx4_reg;
        tp2y    = k2_4_reg * ny4_reg;
        tp1x_sh = tp1x >>> FRAC;
        tp1y_sh = tp1y >>> FRAC;
        tp2x_sh = tp2x >>> FRAC;
        tp2y_sh = tp2y >>> FRAC;
    end

    // Apply impulse and separation, or pass the pair through untouched.
    always_comb
    begin
        res_next.collided      = hit5_reg;
        res_next.new_first_x   = pair5_reg.first_x;
        res_next.new_first_y   = pair5_reg.first_y;
        res_next.new_first_vx  = pair5_reg.first_vx;
        res_next.new_first_vy  = pair5_reg.first_vy;
        res_next.new_second_x  = pair5_reg.second_x;
        res_next.new_second_y  = pair5_reg.second_y;
        res_next.new_second_vx = pair5_reg.second_vx;
        res_next.new_second_vy = pair5_reg.second_vy;
        if (hit5_reg)
        begin
            res_next.new_first_x   = dcr_pkg::sat32(64'(pair5_reg.first_x) - 64'(px5_reg));
            res_next.new_first_y   = dcr_pkg::sat32(64'(pair5_reg.first_y) - 64'(py5_reg));
            res_next.new_second_x  = dcr_pkg::sat32(64'(pair5_reg.second_x) + 64'(px5_reg));
            res_next.new_second_y  = dcr_pkg::sat32(64'(pair5_reg.second_y) + 64'(py5_reg));
            res_next.new_first_vx  = dcr_pkg::sat32(64'(pair5_reg.first_vx) + 64'(t1x5_reg));
            res_next.new_first_vy  = dcr_pkg::sat32(64'(pair5_reg.first_vy) + 64'(t1y5_reg));
            res_next.new_second_vx = dcr_pkg::sat32(64'(pair5_reg.second_vx) - 64'(t2x5_reg));
            res_next.new_second_vy = dcr_pkg::sat32(64'(pair5_reg.second_vy) - 64'(t2y5_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= src_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side;
            nx1_reg   <= nx;
            ny1_reg   <= ny;
            w1_1_reg  <= msum_zero ? HALF : qm;
            w2_1_reg  <= msum_zero ? HALF : w2_full[WW-1:0];
            dpx1_reg  <= dpx;
            dpy1_reg  <= dpy;

            pair2_reg <= side1_reg.pair;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            w1_2_reg  <= w1_1_reg;
            w2_2_reg  <= w2_1_reg;
            rvq2_reg  <= rv_sh[RQW-1:0];
            ov2_reg   <= gap[CW-1:1];
            hit2_reg  <= side1_reg.overlap && (rv[RVW-1] || rv == '0);

            pair3_reg <= pair2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            w1_3_reg  <= w1_2_reg;
            w2_3_reg  <= w2_2_reg;
            s3_reg    <= sp_sh[SW-1:0];
            ppx3_reg  <= ppx;
            ppy3_reg  <= ppy;
            hit3_reg  <= hit2_reg;

            pair4_reg <= pair3_reg;
            nx4_reg   <= nx3_reg;
            ny4_reg   <= ny3_reg;
            k1_4_reg  <= kp1_sh[KW-1:0];
            k2_4_reg  <= kp2_sh[KW-1:0];
            px4_reg   <= ppx_sh[PW-1:0];
            py4_reg   <= ppy_sh[PW-1:0];
            hit4_reg  <= hit3_reg;

            pair5_reg <= pair4_reg;
            t1x5_reg  <= tp1x_sh[TW-1:0];
            t1y5_reg  <= tp1y_sh[TW-1:0];
            t2x5_reg  <= tp2x_sh[TW-1:0];
            t2y5_reg  <= tp2y_sh[TW-1:0];
            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
            hit5_reg  <= hit4_reg;

            res6_reg  <= res_next;
        end
    end

    assign dst_valid = vld6_reg;
    assign result    = res6_reg;
endmodule

FILE: hw/rtl/disc_collision_resolver.sv
// Two-disc collision resolver: overlap test, impulse along the unit normal,
// half-overlap separation. Depends on dcr_pkg and the dcr_* pipeline modules.
//
// Use:
//   pair channel (pair_valid / pair_ready / pair) carries one disc pair per
//   transfer; result channel (result_valid / result_ready / result) returns
//   exactly one result per pair, in order. cfg_we / cfg_wdata write the
//   restitution register (Q1.8); write it only while idle. The pipeline has
//   three front stages (deltas, squares, overlap compare), 32 square-root
//   stages (one root bit each), FRAC_BITS + 1 divider stages for the normal
//   and the mass weights, and six stages of impulse and separation math
//   ending in the output register. Throughput is one pair per cycle while no
//   result is held in the output register with result_ready low.
//   The whole pipeline advances together: when a result waits in the output
//   register with result_ready low, every stage holds and pair_ready drops;
//   nothing is lost or repeated. Bubbles travel as cleared valid bits.
//   Reset clears all valid bits and loads restitution with 1.0 (256).
`timescale 1ns / 1ps
module disc_collision_resolver #(
    parameter int FRAC_BITS = dcr_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pair_valid,
    output logic                          pair_ready,
    input  dcr_pkg::disc_pair_t           pair,
    output logic                          result_valid,
    input  logic                          result_ready,
    output dcr_pkg::disc_result_t         result,
    input  logic                          cfg_we,
    input  logic [dcr_pkg::REST_W-1:0]    cfg_wdata
);
    localparam int SQ_SIDE_W = $bits(dcr_pkg::sq_side_t);
    localparam int DV_SIDE_W = $bits(dcr_pkg::dv_side_t);
    localparam int CW        = dcr_pkg::COORD_W;

    logic [dcr_pkg::REST_W-1:0]   restitution_reg;
    logic                         en;

    logic                         fr_valid;
    logic [dcr_pkg::RAD_W-1:0]    fr_radicand;
    dcr_pkg::sq_side_t            fr_side;

    logic                         sq_valid;
    logic [dcr_pkg::ROOT_W-1:0]   sq_dist;
    logic [SQ_SIDE_W-1:0]         sq_side_bits;
    dcr_pkg::sq_side_t            sq_side;
    dcr_pkg::dv_side_t            dv_side_in;
    logic [CW-1:0]                msum;

    logic                         nx_valid;
    logic [FRAC_BITS:0]           nx_quot;
    logic [DV_SIDE_W-1:0]         nx_side_bits;
    logic                         ny_valid;
    logic [FRAC_BITS:0]           ny_quot;
    logic                         ny_neg;
    logic                         m_valid;
    logic [FRAC_BITS:0]           m_quot;
    logic                         m_rem_nz;
    logic                         m_zero;

    // Freeze everything while a finished result waits for the receiver.
    assign en         = !result_valid || result_ready;
    assign pair_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= dcr_pkg::REST_W'(dcr_pkg::RESTITUTION_RST);
        else if (cfg_we)
            restitution_reg <= cfg_wdata;
    end

    dcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (pair_valid),
        .pair      (pair),
        .dst_valid (fr_valid),
        .radicand  (fr_radicand),
        .dst_side  (fr_side)
    );

    dcr_sqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (fr_valid),
        .radicand  (fr_radicand),
        .src_side  (fr_side),
        .dst_valid (sq_valid),
        .root      (sq_dist),
        .dst_side  (sq_side_bits)
    );

    // Gather what the back end needs; the normal divider carries it along.
    always_comb
    begin
        sq_side                = dcr_pkg::sq_side_t'(sq_side_bits);
        dv_side_in.pair        = sq_side.pair;
        dv_side_in.rs          = sq_side.rs;
        dv_side_in.root_dist   = sq_dist;
        dv_side_in.neg_dx      = sq_side.neg_dx;
        dv_side_in.coincident  = sq_side.coincident;
        dv_side_in.overlap     = sq_side.overlap;
        msum = {1'b0, sq_side.pair.first_mass} + {1'b0, sq_side.pair.second_mass};
    end

    dcr_div #(
        .FRAC   (FRAC_BITS),
        .SIDE_W (DV_SIDE_W)
    ) u_div_nx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (sq_valid),
        .numer     (sq_side.adx),
        .denom     (sq_dist),
        .src_side  (dv_side_in),
        .dst_valid (nx_valid),
        .quot      (nx_quot),
        .rem_nz    (),
        .dst_side  (nx_side_bits)
    );

    dcr_div #(
        .FRAC   (FRAC_BITS),
        .SIDE_W (1)
    ) u_div_ny (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (sq_valid),
        .numer     (sq_side.ady),
        .denom     (sq_dist),
        .src_side  (sq_side.neg_dy),
        .dst_valid (ny_valid),
        .quot      (ny_quot),
        .rem_nz    (),
        .dst_side  (ny_neg)
    );

    dcr_div #(
        .FRAC   (FRAC_BITS),
        .SIDE_W (1)
    ) u_div_mass (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (sq_valid),
        .numer     ({1'b0, sq_side.pair.first_mass}),
        .denom     (msum),
        .src_side  (msum == '0),
        .dst_valid (m_valid),
        .quot      (m_quot),
        .rem_nz    (m_rem_nz),
        .dst_side  (m_zero)
    );

    dcr_resolve #(
        .FRAC (FRAC_BITS)
    ) u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .src_valid   (nx_valid),
        .side        (dcr_pkg::dv_side_t'(nx_side_bits)),
        .neg_dy      (ny_neg),
        .qx          (nx_quot),
        .qy          (ny_quot),
        .qm          (m_quot),
        .m_rem_nz    (m_rem_nz),
        .msum_zero   (m_zero),
        .restitution (restitution_reg),
        .dst_valid   (result_valid),
        .result      (result)
    );

`ifndef SYNTH
    // The three dividers run in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (ny_valid == nx_valid) && (m_valid == nx_valid))
        else $error("divider valid bits out of step");

    // An overlapping pair always has an integer distance below the radius sum.
    a_dist_below_rs: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && sq_side.overlap |-> sq_dist < sq_side.rs)
        else $error("square root not below radius sum for an overlapping pair");

    // A held result freezes the whole pipeline, front stage included.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(fr_valid) && $stable(sq_valid))
        else $error("pipeline advanced during a stall");
`endif
endmodule
